>>> rtl/nearest_point_search_2d_assert.svh
`ifndef NEAREST_POINT_SEARCH_2D_ASSERT_SVH
`define NEAREST_POINT_SEARCH_2D_ASSERT_SVH

// same-cycle implication, checked outside reset
`define NPSD_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("npsd assertion failed");

// next-cycle implication, checked outside reset
`define NPSD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("npsd assertion failed");

`endif

>>> rtl/npsd_pkg.sv
package npsd_pkg;

  localparam int DIST_W      = 33;
  localparam int IDX_W       = 8;
  localparam int IO_COORD_W  = 16;
  localparam int PCOUNT_W    = 9;
  localparam int APB_ADDR_W  = 3;
  localparam int APB_DATA_W  = 32;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // register select is paddr[2]
  localparam logic REG_POINT_COUNT = 1'b0;
  localparam logic REG_TAKE_ROOT   = 1'b1;

  typedef struct packed {
    logic                          cmd;
    logic [IDX_W-1:0]              slot;
    logic signed [IO_COORD_W-1:0]  px;
    logic signed [IO_COORD_W-1:0]  py;
  } req_t;

  typedef struct packed {
    logic                          found;
    logic [DIST_W-1:0]             distance;
    logic [IDX_W-1:0]              nearest_index;
    logic signed [IO_COORD_W-1:0]  nearest_x;
    logic signed [IO_COORD_W-1:0]  nearest_y;
  } rsp_t;

  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctl_t;

endpackage

>>> rtl/npsd_cell.sv
module npsd_cell #(
  parameter int CB = 16
) (
  input  logic                 clk,
  input  npsd_pkg::cell_ctl_t  ctl,
  input  logic [CB-1:0]        nbr_x,
  input  logic [CB-1:0]        nbr_y,
  input  logic [CB-1:0]        wr_x,
  input  logic [CB-1:0]        wr_y,
  output logic [CB-1:0]        pt_x,
  output logic [CB-1:0]        pt_y
);

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      pt_x <= wr_x;
      pt_y <= wr_y;
    end else if (ctl.shift) begin
      pt_x <= nbr_x;
      pt_y <= nbr_y;
    end
  end

endmodule

>>> rtl/npsd_sqrt.sv
module npsd_sqrt #(
  parameter int W = 35
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [W-1:0]          radicand,
  output logic                  done,
  output logic [(W+1)/2-1:0]    root
);

  localparam int RW   = (W + 1) / 2;
  localparam int RADW = 2 * RW;
  localparam int REMW = RW + 3;
  localparam int CW   = (RW > 1) ? $clog2(RW) : 1;

  logic [RADW-1:0] rad;
  logic [REMW-1:0] rem;
  logic [CW-1:0]   cnt;
  logic            busy;

  logic [REMW-1:0] shifted;
  logic [REMW-1:0] trial;

  // restoring square root, one result bit per cycle
  assign shifted = {rem[REMW-3:0], rad[RADW-1 -: 2]};
  assign trial   = REMW'({root, 2'b01});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad  <= RADW'(radicand);
      rem  <= '0;
      root <= '0;
      cnt  <= CW'(RW - 1);
    end else if (busy) begin
      rad <= rad << 2;
      cnt <= cnt - 1'b1;
      if (shifted >= trial) begin
        rem  <= shifted - trial;
        root <= {root[RW-2:0], 1'b1};
      end else begin
        rem  <= shifted;
        root <= {root[RW-2:0], 1'b0};
      end
    end
  end

endmodule

>>> rtl/nearest_point_search_2d.sv
// Load item: written into its ring cell when accepted, one load per cycle while no query is in progress.
// Query item: the point ring rotates once through all MAX_POINTS cells, one
// distance per cycle, then the pipe drains and, with take_root set and a point
// found, a bit-serial square root runs on the best squared distance.
// One query at a time; the result register frees the input side once loaded.
// Reset (synchronous): point_count 0, take_root 1, point table left unwritten.
`include "nearest_point_search_2d_assert.svh"

module nearest_point_search_2d #(
  parameter int MAX_POINTS = 256,
  parameter int COORD_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 req_valid,
  output logic                                 req_stall,
  input  npsd_pkg::req_t                       req,
  output logic                                 rsp_valid,
  input  logic                                 rsp_stall,
  output npsd_pkg::rsp_t                       rsp,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [npsd_pkg::APB_ADDR_W-1:0]      paddr,
  input  logic [npsd_pkg::APB_DATA_W-1:0]      pwdata,
  output logic [npsd_pkg::APB_DATA_W-1:0]      prdata,
  output logic                                 pready
);

  localparam int CB    = COORD_BITS;
  localparam int IW    = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int DW    = CB + 1;
  localparam int SQW   = 2 * DW;
  localparam int SUMW  = SQW + 1;
  localparam int BESTW = (SUMW > 64) ? 64 : SUMW;
  localparam int RW    = (BESTW + 1) / 2;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_DRAIN = 3'd2;
  localparam logic [2:0] S_ROOT  = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  // configuration
  logic [npsd_pkg::PCOUNT_W-1:0] point_count;
  logic                          take_root;
  logic                          cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      point_count <= '0;
      take_root   <= 1'b1;
    end else if (cfg_wr) begin
      if (paddr[2] == npsd_pkg::REG_TAKE_ROOT) begin
        take_root <= pwdata[0];
      end else begin
        point_count <= pwdata[npsd_pkg::PCOUNT_W-1:0];
      end
    end
  end

  assign prdata = (paddr[2] == npsd_pkg::REG_TAKE_ROOT) ?
                  npsd_pkg::APB_DATA_W'(take_root) :
                  npsd_pkg::APB_DATA_W'(point_count);

  // control
  logic [2:0]    state;
  logic [IW-1:0] scan_cnt;
  logic [1:0]    drain_cnt;
  logic          req_acc;
  logic          load_en;
  logic          sq_start;
  logic          sq_done;
  logic [RW-1:0] sq_root;

  assign req_stall = (state != S_IDLE);
  assign req_acc   = req_valid && !req_stall;
  assign load_en   = req_acc && (req.cmd == npsd_pkg::CMD_LOAD) &&
                     (32'(req.slot) < MAX_POINTS);

  // input coordinates: low CB bits of the raw field
  logic [31:0]          in_x_raw;
  logic [31:0]          in_y_raw;
  logic [CB-1:0]        in_x;
  logic [CB-1:0]        in_y;

  assign in_x_raw = {16'h0, req.px};
  assign in_y_raw = {16'h0, req.py};
  assign in_x     = in_x_raw[CB-1:0];
  assign in_y     = in_y_raw[CB-1:0];

  // point ring: cell 0 is the head seen by the distance pipe
  logic [CB-1:0]         ring_x [MAX_POINTS];
  logic [CB-1:0]         ring_y [MAX_POINTS];
  npsd_pkg::cell_ctl_t   cell_ctl [MAX_POINTS];

  for (genvar i = 0; i < MAX_POINTS; i++) begin : g_cell
    assign cell_ctl[i].load  = load_en && (32'(req.slot) == i);
    assign cell_ctl[i].shift = (state == S_SCAN);

    npsd_cell #(
      .CB (CB)
    ) u_cell (
      .clk   (clk),
      .ctl   (cell_ctl[i]),
      .nbr_x (ring_x[(i + 1) % MAX_POINTS]),
      .nbr_y (ring_y[(i + 1) % MAX_POINTS]),
      .wr_x  (in_x),
      .wr_y  (in_y),
      .pt_x  (ring_x[i]),
      .pt_y  (ring_y[i])
    );
  end

  // query point
  logic signed [CB-1:0] qx;
  logic signed [CB-1:0] qy;

  always_ff @(posedge clk) begin
    if (req_acc && req.cmd == npsd_pkg::CMD_QUERY) begin
      qx <= signed'(in_x);
      qy <= signed'(in_y);
    end
  end

  // stage 1: absolute differences
  logic signed [CB-1:0] head_x;
  logic signed [CB-1:0] head_y;
  logic signed [DW-1:0] diff_x;
  logic signed [DW-1:0] diff_y;
  logic [DW-1:0]        adx;
  logic [DW-1:0]        ady;

  assign head_x = signed'(ring_x[0]);
  assign head_y = signed'(ring_y[0]);
  assign diff_x = DW'(qx) - DW'(head_x);
  assign diff_y = DW'(qy) - DW'(head_y);
  assign adx    = diff_x[DW-1] ? DW'(-diff_x) : DW'(diff_x);
  assign ady    = diff_y[DW-1] ? DW'(-diff_y) : DW'(diff_y);

  logic                 v1;
  logic [IW-1:0]        idx1;
  logic signed [CB-1:0] x1;
  logic signed [CB-1:0] y1;
  logic [DW-1:0]        dx1;
  logic [DW-1:0]        dy1;

  // stage 2: squares
  logic                 v2;
  logic [IW-1:0]        idx2;
  logic signed [CB-1:0] x2;
  logic signed [CB-1:0] y2;
  logic [SQW-1:0]       sqx;
  logic [SQW-1:0]       sqy;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= (state == S_SCAN) && (32'(scan_cnt) < 32'(point_count));
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    idx1 <= scan_cnt;
    x1   <= head_x;
    y1   <= head_y;
    dx1  <= adx;
    dy1  <= ady;
    idx2 <= idx1;
    x2   <= x1;
    y2   <= y1;
    sqx  <= dx1 * dx1;
    sqy  <= dy1 * dy1;
  end

  // stage 3: sum, saturate, keep strict minimum
  logic [SUMW-1:0]  sum;
  logic [BESTW-1:0] d_sat;

  assign sum = SUMW'(sqx) + SUMW'(sqy);

  if (SUMW > 64) begin : g_sat
    assign d_sat = (|sum[SUMW-1:64]) ? '1 : sum[63:0];
  end else begin : g_nosat
    assign d_sat = sum;
  end

  logic                 have;
  logic [BESTW-1:0]     best;
  logic [IW-1:0]        best_idx;
  logic signed [CB-1:0] bx;
  logic signed [CB-1:0] by;

  always_ff @(posedge clk) begin
    if (rst) begin
      have <= 1'b0;
    end else if (req_acc && req.cmd == npsd_pkg::CMD_QUERY) begin
      have <= 1'b0;
    end else if (v2 && (!have || d_sat < best)) begin
      have <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (v2 && (!have || d_sat < best)) begin
      best     <= d_sat;
      best_idx <= idx2;
      bx       <= x2;
      by       <= y2;
    end
  end

  assign sq_start = (state == S_DRAIN) && (drain_cnt == 2'd2) && have && take_root;

  npsd_sqrt #(
    .W (BESTW)
  ) u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sq_start),
    .radicand (best),
    .done     (sq_done),
    .root     (sq_root)
  );

  logic [npsd_pkg::DIST_W-1:0] res_dist;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      scan_cnt  <= '0;
      drain_cnt <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (req_acc && req.cmd == npsd_pkg::CMD_QUERY) begin
            state    <= S_SCAN;
            scan_cnt <= '0;
          end
        end
        S_SCAN: begin
          if (scan_cnt == IW'(MAX_POINTS - 1)) begin
            scan_cnt  <= '0;
            drain_cnt <= '0;
            state     <= S_DRAIN;
          end else begin
            scan_cnt <= scan_cnt + 1'b1;
          end
        end
        S_DRAIN: begin
          // final drain step: best holds the final minimum
          if (drain_cnt == 2'd2) begin
            state <= sq_start ? S_ROOT : S_DONE;
          end else begin
            drain_cnt <= drain_cnt + 1'b1;
          end
        end
        S_ROOT: begin
          if (sq_done) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!rsp_valid || !rsp_stall) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DRAIN && drain_cnt == 2'd2) begin
      res_dist <= npsd_pkg::DIST_W'(best);
    end else if (state == S_ROOT && sq_done) begin
      res_dist <= npsd_pkg::DIST_W'(sq_root);
    end
  end

  // result register
  logic rsp_load;

  assign rsp_load = (state == S_DONE) && (!rsp_valid || !rsp_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp.found <= have;
      if (have) begin
        rsp.distance      <= res_dist;
        rsp.nearest_index <= npsd_pkg::IDX_W'(best_idx);
        rsp.nearest_x     <= npsd_pkg::IO_COORD_W'(bx);
        rsp.nearest_y     <= npsd_pkg::IO_COORD_W'(by);
      end else begin
        rsp.distance      <= '1;
        rsp.nearest_index <= '0;
        rsp.nearest_x     <= '0;
        rsp.nearest_y     <= '0;
      end
    end
  end

  `NPSD_ASSERT_NOW(a_ring_home, clk, rst, state == S_IDLE, scan_cnt == '0)
  `NPSD_ASSERT_NOW(a_root_in_root, clk, rst, sq_done, state == S_ROOT)
  `NPSD_ASSERT_NEXT(a_empty_result, clk, rst, rsp_load && !have, rsp.distance == '1 && rsp.nearest_index == '0)

endmodule

>>> tb/sv/nearest_point_search_2d_checker.sv
`timescale 1ns / 1ps

module point_search_checker
  import npsd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  input  logic                  req_stall,
  input  req_t                  req,
  input  logic                  rsp_valid,
  input  logic                  rsp_stall,
  input  rsp_t                  rsp,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  input  logic                  pready,
  output int                    fail_count,
  output int                    pending
);

  localparam int TABLE_DEPTH = 256;

  logic signed [IO_COORD_W-1:0] dest_x [TABLE_DEPTH];
  logic signed [IO_COORD_W-1:0] dest_y [TABLE_DEPTH];
  logic [PCOUNT_W-1:0]          search_count = '0;
  logic                         root_mode = 1'b1;

  rsp_t nearest_q [$];
  rsp_t want;
  int   fails = 0;
  int   waiting = 0;

  assign fail_count = fails;
  assign pending    = waiting;

  initial begin
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      dest_x[i] = '0;
      dest_y[i] = '0;
    end
  end

  // bit-by-bit floor square root, result fits in 17 bits
  function automatic logic [DIST_W-1:0] floor_sqrt(input longint unsigned v);
    longint unsigned r;
    longint unsigned t;
    r = 0;
    for (int b = 17; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= v) r = t;
    end
    return r[DIST_W-1:0];
  endfunction

  function automatic rsp_t nearest_of(input logic signed [IO_COORD_W-1:0] sx,
                                      input logic signed [IO_COORD_W-1:0] sy);
    rsp_t            r;
    int              n;
    longint          dx;
    longint          dy;
    longint unsigned d2;
    longint unsigned best;
    int              best_j;
    bit              have;
    r = '0;
    have = 1'b0;
    best = 0;
    best_j = 0;
    n = (search_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(search_count);
    for (int j = 0; j < n; j++) begin
      dx = longint'(sx) - longint'(dest_x[j]);
      dy = longint'(sy) - longint'(dest_y[j]);
      d2 = longint'(dx * dx) + longint'(dy * dy);
      // strict compare keeps the lowest index on a tie
      if (!have || d2 < best) begin
        have = 1'b1;
        best = d2;
        best_j = j;
      end
    end
    if (!have) begin
      r.distance = '1;
      return r;
    end
    r.found         = 1'b1;
    r.distance      = root_mode ? floor_sqrt(best) : best[DIST_W-1:0];
    r.nearest_index = best_j[IDX_W-1:0];
    r.nearest_x     = dest_x[best_j];
    r.nearest_y     = dest_y[best_j];
    return r;
  endfunction

  task automatic check_field(input string name, input longint want_v, input longint got_v);
    if (want_v != got_v) begin
      $error("%s: expected %0d, got %0d", name, want_v, got_v);
      fails++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      search_count = '0;
      root_mode = 1'b1;
      nearest_q.delete();
    end else begin
      // results first: an item taken at this edge cannot answer at it
      if (rsp_valid && !rsp_stall) begin
        if (nearest_q.size() == 0) begin
          $error("result with no query waiting: distance %0d index %0d",
                 rsp.distance, rsp.nearest_index);
          fails++;
        end else begin
          want = nearest_q.pop_front();
          check_field("found", longint'(want.found), longint'(rsp.found));
          check_field("distance", longint'(want.distance), longint'(rsp.distance));
          check_field("nearest_index", longint'(want.nearest_index),
                      longint'(rsp.nearest_index));
          check_field("nearest_x", longint'(want.nearest_x), longint'(rsp.nearest_x));
          check_field("nearest_y", longint'(want.nearest_y), longint'(rsp.nearest_y));
        end
      end
      if (req_valid && !req_stall) begin
        if (req.cmd == CMD_LOAD) begin
          dest_x[req.slot] = req.px;
          dest_y[req.slot] = req.py;
        end else begin
          nearest_q.push_back(nearest_of(req.px, req.py));
        end
      end
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_POINT_COUNT) search_count = pwdata[PCOUNT_W-1:0];
        else root_mode = pwdata[0];
      end
    end
    waiting = nearest_q.size();
  end

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import npsd_pkg::*;

  localparam int TABLE_DEPTH  = 256;
  localparam int DRAIN_CYCLES = 300;
  localparam int ITEM_TARGET  = 1700;
  localparam int CALM_FROM    = 1450;

  logic                  clk;
  logic                  rst;
  logic                  req_valid;
  logic                  req_stall;
  req_t                  req;
  logic                  rsp_valid;
  logic                  rsp_stall;
  rsp_t                  rsp;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  int  fail_count;
  int  pending;
  bit  idle_on;
  bit  loaded [TABLE_DEPTH];
  int  items_sent;
  int  cur_count;
  int  stall_left;

  nearest_point_search_2d dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  point_search_checker checker_i (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #40000000;
    $display("tb: failure");
    $finish;
  end

  // result-side back-pressure in random bursts
  initial begin
    rsp_stall = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) stall_left--;
      else if (idle_on && $urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 18);
      rsp_stall = (stall_left > 0);
    end
  end

  function automatic logic signed [IO_COORD_W-1:0] pick_coord();
    logic signed [IO_COORD_W-1:0] v;
    case ($urandom_range(0, 7))
      0:       v = 16'sh8000;
      1:       v = 16'sh7fff;
      2:       v = $urandom_range(0, 1) ? 16'sd0 : -16'sd1;
      3, 4, 5: v = 16'($urandom_range(0, 16)) - 16'sd8;  // dense, many ties
      default: v = 16'($urandom);
    endcase
    return v;
  endfunction

  task automatic send_item(input req_t item);
    int gap;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      req_valid = 1'b0;
      gap = $urandom_range(1, 18);
      repeat (gap) @(negedge clk);
    end
    req = item;
    req_valid = 1'b1;
    do @(posedge clk); while (req_stall);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic load_point(input int slot, input logic signed [IO_COORD_W-1:0] x,
                            input logic signed [IO_COORD_W-1:0] y);
    req_t item;
    item.cmd  = CMD_LOAD;
    item.slot = slot[IDX_W-1:0];
    item.px   = x;
    item.py   = y;
    loaded[slot] = 1'b1;
    send_item(item);
  endtask

  task automatic query_point(input logic signed [IO_COORD_W-1:0] x,
                             input logic signed [IO_COORD_W-1:0] y);
    req_t item;
    item.cmd  = CMD_QUERY;
    item.slot = IDX_W'($urandom);  // don't care for a query
    item.px   = x;
    item.py   = y;
    send_item(item);
  endtask

  // block idle: all results in and any trailing load finished
  task automatic settle();
    req_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic sel, input logic [APB_DATA_W-1:0] value);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {sel, 2'b00};
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // every entry a query can reach must hold a point
  task automatic fill_table();
    int n;
    n = (cur_count > TABLE_DEPTH) ? TABLE_DEPTH : cur_count;
    for (int i = 0; i < n; i++)
      if (!loaded[i]) load_point(i, pick_coord(), pick_coord());
  endtask

  initial begin
    int pc;
    int n_items;
    req_valid = 1'b0;
    req       = '0;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = '0;
    pwdata    = '0;
    idle_on   = 1'b0;
    items_sent = 0;
    cur_count = 0;
    rst = 1'b1;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // empty search straight out of reset
    query_point(16'sh8000, 16'sh7fff);
    load_point(0, 16'sh8000, 16'sh8000);
    load_point(1, 16'sh7fff, 16'sh7fff);
    load_point(2, 16'sd0, 16'sd0);
    load_point(3, 16'sd0, 16'sd0);
    load_point(255, 16'sh7fff, 16'sh8000);
    settle();
    write_reg(REG_TAKE_ROOT, 32'd0);
    write_reg(REG_POINT_COUNT, 32'd1);
    cur_count = 1;
    query_point(16'sh7fff, 16'sh7fff);  // largest squared distance
    query_point(16'sh8000, 16'sh8000);
    settle();
    write_reg(REG_POINT_COUNT, 32'd4);
    cur_count = 4;
    query_point(16'sd0, 16'sd0);  // tie between entries 2 and 3
    query_point(16'sd1, 16'sd1);
    query_point(16'sh7fff, 16'sh7fff);
    query_point(16'sh8000, 16'sh7fff);
    settle();
    write_reg(REG_TAKE_ROOT, 32'd1);
    query_point(16'sd5, 16'sd12);
    query_point(16'sd3, 16'sd3);
    query_point(-16'sd1, -16'sd1);
    settle();
    write_reg(REG_POINT_COUNT, 32'd1);
    cur_count = 1;
    query_point(16'sh7fff, 16'sh7fff);  // root of the largest distance
    settle();
    write_reg(REG_POINT_COUNT, 32'd0);
    cur_count = 0;
    query_point(16'sd0, 16'sd0);

    while (items_sent < ITEM_TARGET) begin
      settle();
      idle_on = (items_sent >= CALM_FROM) ? 1'b0 : ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 7))
        0:       pc = 0;
        1:       pc = 1;
        2:       pc = TABLE_DEPTH;
        3:       pc = $urandom_range(TABLE_DEPTH + 1, 510);  // above the table size
        4:       pc = 511;
        5:       pc = $urandom_range(2, 16);
        default: pc = $urandom_range(1, TABLE_DEPTH);
      endcase
      write_reg(REG_POINT_COUNT, APB_DATA_W'(pc));
      cur_count = pc;
      if ($urandom_range(0, 1)) write_reg(REG_TAKE_ROOT, APB_DATA_W'($urandom_range(0, 1)));
      fill_table();
      n_items = $urandom_range(40, 100);
      repeat (n_items) begin
        if ($urandom_range(0, 9) < 4) query_point(pick_coord(), pick_coord());
        else load_point($urandom_range(0, TABLE_DEPTH - 1), pick_coord(), pick_coord());
      end
    end

    settle();
    if (fail_count == 0 && pending == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule

>>> nearest_point_search_2d.f
+incdir+rtl
rtl/npsd_pkg.sv
rtl/npsd_cell.sv
rtl/npsd_sqrt.sv
rtl/nearest_point_search_2d.sv
tb/sv/nearest_point_search_2d_checker.sv
tb/sv/testbench.sv
